### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the checker file. Each macro expects clk
// and rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SGBC_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sgbc: assertion failed");

// Next-cycle implication, disabled during reset
`define SGBC_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sgbc: assertion failed");

`endif

### design/sgbc_pkg.sv
// ----------------------------------------------------------------------------
// sgbc_pkg
// Shared types and constants of the stationary gyro bias calibrator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sgbc_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_TARGET  = 3'd0;
    localparam logic [2:0] REG_LIM_GX  = 3'd1;
    localparam logic [2:0] REG_LIM_AZ  = 3'd6;

    // Configuration reset values
    localparam logic [15:0] TARGET_RST    = 16'd10000;
    localparam logic [30:0] GYRO_LIM_RST  = 31'd64;
    localparam logic [30:0] ACCEL_LIM_RST = 31'd16;

    // Axis numbering: gyro x, y, z then accel x, y, z
    localparam logic [2:0] LAST_GYRO = 3'd2;
    localparam logic [2:0] LAST_AXIS = 3'd5;

    localparam logic [6:0] PCT_FULL = 7'd100;

    // Multiplier operand selects
    localparam logic [2:0] MUL_V   = 3'd0;  // new sample squared
    localparam logic [2:0] MUL_OLD = 3'd1;  // evicted sample squared
    localparam logic [2:0] MUL_LHS = 3'd2;  // N * sum of squares
    localparam logic [2:0] MUL_S   = 3'd3;  // sum squared
    localparam logic [2:0] MUL_LIM = 3'd4;  // limit * N * N

    typedef struct packed {
        logic       load;       // accept beat, store sample, fetch evicted entry
        logic       mul_start;
        logic [2:0] mul_sel;
        logic       div_start;
        logic       div_prog;   // 1: progress divide, 0: bias divide
        logic [2:0] axis;
        logic       commit;     // window and accumulator update
        logic       finish;     // bias result taken
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic busy;
        logic full;
        logic still;
        logic reached;
        logic out_free;
    } stat_t;

endpackage

### design/sgbc_datapath.sv
// ----------------------------------------------------------------------------
// sgbc_datapath
// Sample window memory, running sums, shared digit-serial multiplier,
// shared restoring divider, bias accumulators and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sgbc_datapath #(
    parameter int WINDOW_DEPTH = 256,
    parameter int SAMPLE_BITS  = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  sgbc_pkg::cmd_t             cmd,
    output sgbc_pkg::stat_t            stat,
    input  logic [6*SAMPLE_BITS-1:0]   sample,
    input  logic                       cfg_we,
    input  logic [2:0]                 cfg_index,
    input  logic [30:0]                cfg_data,
    output logic                       res_valid,
    input  logic                       res_ready,
    output logic [3*SAMPLE_BITS+8:0]   res_data
);
    import sgbc_pkg::*;

    localparam int SB        = SAMPLE_BITS;
    localparam int NB        = $clog2(WINDOW_DEPTH + 1);
    localparam int HW        = $clog2(WINDOW_DEPTH);
    localparam int SW        = SB + NB + 1;
    localparam int QW        = 2 * SB + NB;
    localparam int AW        = (QW > 31) ? QW : 31;
    localparam int BW        = (SW > 2 * NB) ? SW : 2 * NB;
    localparam int PW        = AW + BW;
    localparam int MUL_STEPS = (BW + 7) / 8;
    localparam int MCW       = $clog2(MUL_STEPS + 1);
    localparam int DW        = SB + 16;
    localparam int DCW       = $clog2(DW + 1);
    localparam logic [NB-1:0]   DEPTH_N = NB'(WINDOW_DEPTH);
    localparam logic [HW-1:0]   HEAD_LAST = HW'(WINDOW_DEPTH - 1);
    localparam logic [BW-1:0]   DEPTH_B = BW'(WINDOW_DEPTH);
    localparam logic [BW-1:0]   DEPTH_SQ = BW'(WINDOW_DEPTH * WINDOW_DEPTH);

    // Sample window memory and current beat
    logic [6*SB-1:0]        win_mem [WINDOW_DEPTH];
    logic [6*SB-1:0]        old_reg;
    logic signed [SB-1:0]   samp_reg [6];

    // Window statistics
    logic signed [SW-1:0]   sum_reg [6];
    logic [QW-1:0]          sq_reg  [6];
    logic [HW-1:0]          head_reg;
    logic [NB-1:0]          fill_reg;
    logic [PW-1:0]          lhs_reg;
    logic [PW-1:0]          rhs_reg;
    logic                   fail_reg;
    logic                   still_reg;

    // Configuration
    logic [15:0]            target_reg;
    logic [30:0]            lim_reg [6];

    // Multiplier
    logic [PW-1:0]          ma_reg;
    logic [BW-1:0]          mb_reg;
    logic [PW-1:0]          mp_reg;
    logic [MCW-1:0]         mcnt_reg;
    logic [2:0]             msel_reg;
    logic [2:0]             max_reg;
    logic                   mbusy_reg;

    // Divider
    logic [DW-1:0]          dq_reg;
    logic [15:0]            drem_reg;
    logic [15:0]            ddiv_reg;
    logic [DCW-1:0]         dcnt_reg;
    logic                   dneg_reg;
    logic                   dprog_reg;
    logic [1:0]             dax_reg;
    logic                   dbusy_reg;

    // Bias accumulation and result
    logic signed [DW-1:0]   acc_reg [3];
    logic [15:0]            cnt_reg;
    logic signed [SB-1:0]   held_reg [3];
    logic [6:0]             prog_reg;
    logic                   done_reg;
    logic                   out_valid_reg;
    logic [3*SB+8:0]        out_data_reg;

    logic                   full_w;
    logic                   pass_w;
    logic [15:0]            tgt_w;
    logic signed [SB-1:0]   v_sel;
    logic signed [SB-1:0]   o_sel;
    logic signed [SW-1:0]   s_sel;
    logic [SB-1:0]          v_abs;
    logic [SB-1:0]          o_abs;
    logic [SW-1:0]          s_abs;
    logic [AW-1:0]          op_a;
    logic [BW-1:0]          op_b;
    logic signed [SB-1:0]   mo_sel;
    logic [DW-1:0]          div_a;
    logic [15:0]            div_b;
    logic                   div_neg;
    logic signed [DW-1:0]   acc_sel;
    logic [16:0]            rem_try;
    logic [16:0]            rem_sub;
    logic [DW-1:0]          quo_mag;
    logic [22:0]            cnt_pct;

    assign full_w = (fill_reg == DEPTH_N);
    assign pass_w = full_w && !fail_reg;
    assign tgt_w  = (target_reg == 16'd0) ? 16'd1 : target_reg;

    assign stat.busy     = mbusy_reg || dbusy_reg;
    assign stat.full     = full_w;
    assign stat.still    = still_reg;
    assign stat.reached  = (cnt_reg >= tgt_w);
    assign stat.out_free = !out_valid_reg || res_ready;

    assign res_valid = out_valid_reg;
    assign res_data  = out_data_reg;

    // Store the beat, read the entry it evicts (old data on same address)
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            win_mem[head_reg] <= sample;
            old_reg           <= win_mem[head_reg];
            for (int i = 0; i < 6; i++)
            begin
                samp_reg[i] <= sample[i*SB +: SB];
            end
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= TARGET_RST;
            for (int i = 0; i < 6; i++)
            begin
                lim_reg[i] <= (i < 3) ? GYRO_LIM_RST : ACCEL_LIM_RST;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_TARGET)
            begin
                target_reg <= cfg_data[15:0];
            end
            else if (cfg_index >= REG_LIM_GX && cfg_index <= REG_LIM_AZ)
            begin
                lim_reg[cfg_index - REG_LIM_GX] <= cfg_data;
            end
        end
    end

    // Multiplier operand select
    always_comb
    begin
        v_sel = samp_reg[cmd.axis];
        o_sel = old_reg[cmd.axis*SB +: SB];
        s_sel = sum_reg[cmd.axis];
        v_abs = v_sel[SB-1] ? SB'(-v_sel) : SB'(v_sel);
        o_abs = o_sel[SB-1] ? SB'(-o_sel) : SB'(o_sel);
        s_abs = s_sel[SW-1] ? SW'(-s_sel) : SW'(s_sel);
        case (cmd.mul_sel)
            MUL_V:
            begin
                op_a = AW'(v_abs);
                op_b = BW'(v_abs);
            end
            MUL_OLD:
            begin
                op_a = AW'(o_abs);
                op_b = BW'(o_abs);
            end
            MUL_LHS:
            begin
                op_a = AW'(sq_reg[cmd.axis]);
                op_b = DEPTH_B;
            end
            MUL_S:
            begin
                op_a = AW'(s_abs);
                op_b = BW'(s_abs);
            end
            MUL_LIM:
            begin
                op_a = AW'(lim_reg[cmd.axis]);
                op_b = DEPTH_SQ;
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // Digit-serial multiplier: one 8-bit digit of the second operand per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mbusy_reg <= 1'b0;
            mcnt_reg  <= '0;
        end
        else if (cmd.mul_start)
        begin
            ma_reg    <= PW'(op_a);
            mb_reg    <= op_b;
            mp_reg    <= '0;
            mcnt_reg  <= MCW'(MUL_STEPS);
            msel_reg  <= cmd.mul_sel;
            max_reg   <= cmd.axis;
            mbusy_reg <= 1'b1;
        end
        else if (mcnt_reg != '0)
        begin
            mp_reg   <= mp_reg + PW'(ma_reg * mb_reg[7:0]);
            ma_reg   <= ma_reg << 8;
            mb_reg   <= mb_reg >> 8;
            mcnt_reg <= mcnt_reg - MCW'(1);
        end
        else
        begin
            mbusy_reg <= 1'b0;
        end
    end

    assign mo_sel = old_reg[max_reg*SB +: SB];

    // Window statistics: apply products, then advance or restart the window
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                sum_reg[i] <= '0;
                sq_reg[i]  <= '0;
            end
            head_reg  <= '0;
            fill_reg  <= '0;
            fail_reg  <= 1'b0;
            still_reg <= 1'b0;
            lhs_reg   <= '0;
            rhs_reg   <= '0;
        end
        else if (cmd.load)
        begin
            fail_reg <= 1'b0;
        end
        else if (mbusy_reg && mcnt_reg == '0)
        begin
            case (msel_reg)
                MUL_V:
                begin
                    sq_reg[max_reg]  <= sq_reg[max_reg] + QW'(mp_reg);
                    sum_reg[max_reg] <= sum_reg[max_reg] + SW'(samp_reg[max_reg]);
                end
                MUL_OLD:
                begin
                    sq_reg[max_reg]  <= sq_reg[max_reg] - QW'(mp_reg);
                    sum_reg[max_reg] <= sum_reg[max_reg] - SW'(mo_sel);
                end
                MUL_LHS:
                begin
                    lhs_reg <= mp_reg;
                end
                MUL_S:
                begin
                    rhs_reg <= mp_reg;
                end
                MUL_LIM:
                begin
                    if ({1'b0, lhs_reg} > ({1'b0, rhs_reg} + {1'b0, mp_reg}))
                    begin
                        fail_reg <= 1'b1;
                    end
                end
                default:
                begin
                    fail_reg <= fail_reg;
                end
            endcase
        end
        else if (cmd.commit)
        begin
            still_reg <= pass_w;
            if (full_w && fail_reg)
            begin
                head_reg <= '0;
                fill_reg <= '0;
                for (int i = 0; i < 6; i++)
                begin
                    sum_reg[i] <= '0;
                    sq_reg[i]  <= '0;
                end
            end
            else
            begin
                head_reg <= (head_reg == HEAD_LAST) ? '0 : head_reg + HW'(1);
                if (!full_w)
                begin
                    fill_reg <= fill_reg + NB'(1);
                end
            end
        end
    end

    // Divider operand select
    always_comb
    begin
        cnt_pct = ({7'd0, cnt_reg} << 6) + ({7'd0, cnt_reg} << 5) + ({7'd0, cnt_reg} << 2);
        acc_sel = acc_reg[cmd.axis[1:0]];
        if (cmd.div_prog)
        begin
            div_a   = DW'(cnt_pct);
            div_b   = tgt_w;
            div_neg = 1'b0;
        end
        else
        begin
            div_a   = acc_sel[DW-1] ? DW'(-acc_sel) : DW'(acc_sel);
            div_b   = cnt_reg;
            div_neg = acc_sel[DW-1];
        end
    end

    assign rem_try = {drem_reg, dq_reg[DW-1]};
    assign rem_sub = rem_try - {1'b0, ddiv_reg};
    assign quo_mag = dq_reg;

    // Restoring divider, one quotient bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dbusy_reg <= 1'b0;
            dcnt_reg  <= '0;
        end
        else if (cmd.div_start)
        begin
            dq_reg    <= div_a;
            drem_reg  <= '0;
            ddiv_reg  <= div_b;
            dcnt_reg  <= DCW'(DW);
            dneg_reg  <= div_neg;
            dprog_reg <= cmd.div_prog;
            dax_reg   <= cmd.axis[1:0];
            dbusy_reg <= 1'b1;
        end
        else if (dcnt_reg != '0)
        begin
            if (!rem_sub[16])
            begin
                drem_reg <= rem_sub[15:0];
                dq_reg   <= {dq_reg[DW-2:0], 1'b1};
            end
            else
            begin
                drem_reg <= rem_try[15:0];
                dq_reg   <= {dq_reg[DW-2:0], 1'b0};
            end
            dcnt_reg <= dcnt_reg - DCW'(1);
        end
        else
        begin
            dbusy_reg <= 1'b0;
        end
    end

    // Bias accumulators, count, held bias and progress
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                acc_reg[i]  <= '0;
                held_reg[i] <= '0;
            end
            cnt_reg  <= '0;
            prog_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                prog_reg <= '0;
                done_reg <= 1'b0;
            end
            if (cmd.commit)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    acc_reg[i] <= pass_w ? acc_reg[i] + DW'(samp_reg[i]) : '0;
                end
                cnt_reg <= pass_w ? cnt_reg + 16'd1 : 16'd0;
            end
            if (dbusy_reg && dcnt_reg == '0)
            begin
                if (dprog_reg)
                begin
                    prog_reg <= (quo_mag > DW'(PCT_FULL)) ? PCT_FULL : quo_mag[6:0];
                end
                else
                begin
                    held_reg[dax_reg] <= dneg_reg ? SB'(-quo_mag) : SB'(quo_mag);
                end
            end
            if (cmd.finish)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    acc_reg[i] <= '0;
                end
                cnt_reg  <= '0;
                done_reg <= 1'b1;
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
            out_data_reg  <= {held_reg[2], held_reg[1], held_reg[0],
                              prog_reg, done_reg, still_reg};
        end
        else if (res_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

endmodule

### design/sgbc_ctrl.sv
// ----------------------------------------------------------------------------
// sgbc_ctrl
// Sequencer: walks each beat through window update, variance test,
// accumulation, divides and result load.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sgbc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  sgbc_pkg::stat_t  stat,
    output sgbc_pkg::cmd_t   cmd
);
    import sgbc_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_UPD   = 4'd1;
    localparam logic [3:0] ST_UPDO  = 4'd2;
    localparam logic [3:0] ST_UPDN  = 4'd3;
    localparam logic [3:0] ST_TLHS  = 4'd4;
    localparam logic [3:0] ST_TS    = 4'd5;
    localparam logic [3:0] ST_TL    = 4'd6;
    localparam logic [3:0] ST_TN    = 4'd7;
    localparam logic [3:0] ST_WIN   = 4'd8;
    localparam logic [3:0] ST_PROG  = 4'd9;
    localparam logic [3:0] ST_PROGD = 4'd10;
    localparam logic [3:0] ST_DIVB  = 4'd11;
    localparam logic [3:0] ST_DIVN  = 4'd12;
    localparam logic [3:0] ST_FIN   = 4'd13;
    localparam logic [3:0] ST_OUT   = 4'd14;
    localparam logic [3:0] ST_WAIT  = 4'd15;

    logic [3:0] state_reg, state_next;
    logic [3:0] ret_reg, ret_next;
    logic [2:0] axis_reg, axis_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
            axis_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            axis_reg  <= axis_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        axis_next  = axis_reg;
        cmd        = '0;
        cmd.axis   = axis_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    axis_next  = '0;
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MUL_V;
                ret_next      = ST_UPDO;
                state_next    = ST_WAIT;
            end
            ST_UPDO:
            begin
                if (stat.full)
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = MUL_OLD;
                    ret_next      = ST_UPDN;
                    state_next    = ST_WAIT;
                end
                else
                begin
                    state_next = ST_UPDN;
                end
            end
            ST_UPDN:
            begin
                if (axis_reg == LAST_AXIS)
                begin
                    axis_next  = '0;
                    state_next = stat.full ? ST_TLHS : ST_WIN;
                end
                else
                begin
                    axis_next  = axis_reg + 3'd1;
                    state_next = ST_UPD;
                end
            end
            ST_TLHS:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MUL_LHS;
                ret_next      = ST_TS;
                state_next    = ST_WAIT;
            end
            ST_TS:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MUL_S;
                ret_next      = ST_TL;
                state_next    = ST_WAIT;
            end
            ST_TL:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MUL_LIM;
                ret_next      = ST_TN;
                state_next    = ST_WAIT;
            end
            ST_TN:
            begin
                if (axis_reg == LAST_AXIS)
                begin
                    axis_next  = '0;
                    state_next = ST_WIN;
                end
                else
                begin
                    axis_next  = axis_reg + 3'd1;
                    state_next = ST_TLHS;
                end
            end
            ST_WIN:
            begin
                cmd.commit = 1'b1;
                state_next = ST_PROG;
            end
            ST_PROG:
            begin
                if (stat.still)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_prog  = 1'b1;
                    ret_next      = ST_PROGD;
                    state_next    = ST_WAIT;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_PROGD:
            begin
                axis_next  = '0;
                state_next = stat.reached ? ST_DIVB : ST_OUT;
            end
            ST_DIVB:
            begin
                cmd.div_start = 1'b1;
                ret_next      = ST_DIVN;
                state_next    = ST_WAIT;
            end
            ST_DIVN:
            begin
                if (axis_reg == LAST_GYRO)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    axis_next  = axis_reg + 3'd1;
                    state_next = ST_DIVB;
                end
            end
            ST_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_WAIT:
            begin
                if (!stat.busy)
                begin
                    state_next = ret_reg;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### design/stationary_gyro_bias_calibrator.sv
// ----------------------------------------------------------------------------
// stationary_gyro_bias_calibrator
// Sliding-window stillness detector with gyro bias averaging.
//
//   channel   direction  payload
//   s_axis    in         six raw IMU samples (gyro x,y,z, accel x,y,z)
//   m_axis    out        stationary, done, progress, bias x,y,z
//   cfg       in         register index and write data
//
// One beat at a time. Each multiply runs on the shared multiplier and each
// divide on the shared divider: a filling window costs 6 multiplies, a full
// one 30, a stationary beat adds 1 or 4 divides. No clearing pass after reset.
// The next beat is taken while the previous result waits on m_axis.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stationary_gyro_bias_calibrator #(
    parameter int WINDOW_DEPTH = 256,
    parameter int SAMPLE_BITS  = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z (SAMPLE_BITS each)
    input  logic [((6*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // stationary, calibration_done, progress_percent[7], bias_x, bias_y, bias_z
    output logic [((3*SAMPLE_BITS+9+7)/8)*8-1:0] m_axis_tdata,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [30:0]         cfg_data
);
    import sgbc_pkg::*;

    localparam int OUT_W = ((3*SAMPLE_BITS+9+7)/8)*8;

    cmd_t                      cmd;
    stat_t                     stat;
    logic [3*SAMPLE_BITS+8:0]  res_data;

    assign cfg_ready    = 1'b1;
    assign m_axis_tdata = OUT_W'(res_data);

    sgbc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sgbc_datapath #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .sample    (s_axis_tdata[6*SAMPLE_BITS-1:0]),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res_data  (res_data)
    );

endmodule

### design/sgbc_checker.sv
// ----------------------------------------------------------------------------
// sgbc_checker
// Port-level checks on the result channel of the calibrator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sgbc_checker #(
    parameter int OUT_W = 64
) (
    input logic             clk,
    input logic             rst_n,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata
);
    import sgbc_pkg::*;

    // Stalled beat holds
    `SGBC_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // A finished average comes only on a stationary beat at full progress
    `SGBC_ASSERT_IMP(a_done_full, m_axis_tvalid && m_axis_tdata[1], m_axis_tdata[0] && m_axis_tdata[8:2] == PCT_FULL)

    // Motion reports no progress and no result
    `SGBC_ASSERT_IMP(a_moving_zero, m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata[8:2] == 7'd0 && !m_axis_tdata[1])

    // Progress saturates
    `SGBC_ASSERT_IMP(a_prog_range, m_axis_tvalid, m_axis_tdata[8:2] <= PCT_FULL)

endmodule

bind stationary_gyro_bias_calibrator sgbc_checker #(
    .OUT_W (OUT_W)
) u_sgbc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
